// ===== rtl/tdc_interval_decimator_top_defines.svh =====
// Assertion macros for the interval decimator RTL.
// Included by the modules that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef TDC_INTERVAL_DECIMATOR_TOP_DEFINES_SVH
`define TDC_INTERVAL_DECIMATOR_TOP_DEFINES_SVH

`ifndef SYNTH
`define TDCID_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TDCID_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TDCID_ASSERT_NOW(label, ante, cons)
`define TDCID_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/tdcid_pkg.sv =====
// Shared types and constants for the interval decimator.
// No dependencies; imported by tdc_interval_decimator_top.
`default_nettype none
package tdcid_pkg;

  localparam int STORE_RECORDS_DEF = 340;
  localparam int FWD_RECORDS_DEF   = 85;

  localparam int CHANNELS   = 3;
  localparam int COUNT_W    = 24;
  localparam int IVAL_W     = 32;
  localparam int PERIOD_W   = 20;
  localparam int DECIM_W    = 16;
  localparam int SSLOT_W    = 9;
  localparam int FSLOT_W    = 7;
  localparam int PADDR_W    = 4;

  localparam logic [PERIOD_W-1:0] REF_PERIOD_RST  = 20'd100000;
  localparam logic [IVAL_W-1:0]   VALID_LIMIT_RST = 32'd20000000;
  localparam logic [DECIM_W-1:0]  DECIMATION_RST  = 16'd200;

  typedef enum logic [1:0] {
    REG_REF_PERIOD  = 2'd0,
    REG_VALID_LIMIT = 2'd1,
    REG_DECIMATION  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [23:0] ref_count_a;
    logic [23:0] stop_a;
    logic [23:0] ref_count_b;
    logic [23:0] stop_b;
    logic [23:0] ref_count_c;
    logic [23:0] stop_c;
    logic [31:0] timestamp;
  } in_word_t;

  typedef struct packed {
    logic [31:0] interval_a;
    logic [31:0] interval_b;
    logic [31:0] interval_c;
    logic [8:0]  store_slot;
    logic        store_bank;
    logic        store_page_full;
    logic [31:0] page_time;
    logic        forward;
    logic [6:0]  fwd_slot;
    logic        fwd_bank;
    logic        fwd_page_full;
  } out_word_t;

endpackage
`default_nettype wire

// ===== rtl/tdc_interval_decimator_top.sv =====
// Interval decimator: readout to interval conversion, page slotting and decimated copy.
// Depends on tdcid_pkg and tdc_interval_decimator_top_defines.svh.
//
// Usage:
//   The input channel (in_valid, in_ready, in_data) takes one converter readout per word.
//   The output channel (out_valid, out_ready, out_data) returns one result word per
//   readout, in order. The APB-style port holds ref_period at 0x0, valid_limit at 0x4
//   and decimation at 0x8; writes are made while the block is idle.
//   A word accepted into the stage-one registers moves on to the output register once
//   that register is free. One word is accepted every cycle while the receiver does
//   not stall; the rate is set by a two-stage pipeline, the first stage holding the
//   three 20 by 32 bit products, the second the adds, limit compare and page counters.
//   Reset clears previous readouts, the readout count, both page indices and banks,
//   and loads the registers with their default values.
//   When the receiver stalls, the output word is held and the first stage can still
//   take one more word; after that in_ready falls until out_ready returns.
`default_nettype none
`include "tdc_interval_decimator_top_defines.svh"
module tdc_interval_decimator_top #(
  parameter int STORE_RECORDS = tdcid_pkg::STORE_RECORDS_DEF,
  parameter int FWD_RECORDS   = tdcid_pkg::FWD_RECORDS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  tdcid_pkg::in_word_t               in_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output tdcid_pkg::out_word_t              out_data,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire [tdcid_pkg::PADDR_W-1:0]      paddr,
  input  wire [31:0]                        pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import tdcid_pkg::*;

  logic [PERIOD_W-1:0] ref_period_r;
  logic [IVAL_W-1:0]   valid_limit_r;
  logic [DECIM_W-1:0]  decimation_r;
  reg_idx_t            reg_idx;
  logic                cfg_wr;

  logic [COUNT_W-1:0]  prev_ref_r  [CHANNELS];
  logic [COUNT_W-1:0]  prev_stop_r [CHANNELS];
  logic [COUNT_W-1:0]  cur_ref     [CHANNELS];
  logic [COUNT_W-1:0]  cur_stop    [CHANNELS];
  logic [IVAL_W-1:0]   prod_nxt    [CHANNELS];
  logic [IVAL_W-1:0]   ds_nxt      [CHANNELS];

  logic                s1_valid_r;
  logic [IVAL_W-1:0]   s1_prod_r [CHANNELS];
  logic [IVAL_W-1:0]   s1_ds_r   [CHANNELS];
  logic [31:0]         s1_ts_r;

  logic [DECIM_W-1:0]  readout_count_r, readout_count_nxt, count_inc;
  logic [SSLOT_W-1:0]  store_index_r, store_index_nxt;
  logic                store_side_r, store_side_nxt;
  logic [FSLOT_W-1:0]  fwd_index_r, fwd_index_nxt;
  logic                fwd_side_r, fwd_side_nxt;

  logic                out_valid_r;
  out_word_t           out_data_r, out_data_nxt;

  logic                in_accept, s1_adv;
  logic                store_full, fwd_full, fwd_take;
  logic [IVAL_W-1:0]   ival [CHANNELS];

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_REF_PERIOD:  prdata = {12'd0, ref_period_r};
      REG_VALID_LIMIT: prdata = valid_limit_r;
      REG_DECIMATION:  prdata = {16'd0, decimation_r};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_period_r  <= REF_PERIOD_RST;
      valid_limit_r <= VALID_LIMIT_RST;
      decimation_r  <= DECIMATION_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_REF_PERIOD:  ref_period_r  <= pwdata[PERIOD_W-1:0];
        REG_VALID_LIMIT: valid_limit_r <= pwdata;
        REG_DECIMATION:  decimation_r  <= pwdata[DECIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and pipeline control.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Stage one: deltas against the previous readout and the reference products.
  always_comb begin
    cur_ref[0]  = in_data.ref_count_a;
    cur_stop[0] = in_data.stop_a;
    cur_ref[1]  = in_data.ref_count_b;
    cur_stop[1] = in_data.stop_b;
    cur_ref[2]  = in_data.ref_count_c;
    cur_stop[2] = in_data.stop_c;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      prod_nxt[ch] = ({8'd0, cur_ref[ch]} - {8'd0, prev_ref_r[ch]}) *
                     {12'd0, ref_period_r};
      ds_nxt[ch]   = {8'd0, cur_stop[ch]} - {8'd0, prev_stop_r[ch]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        prev_ref_r[ch]  <= '0;
        prev_stop_r[ch] <= '0;
      end
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
        for (int ch = 0; ch < CHANNELS; ch++) begin
          prev_ref_r[ch]  <= cur_ref[ch];
          prev_stop_r[ch] <= cur_stop[ch];
        end
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        s1_prod_r[ch] <= prod_nxt[ch];
        s1_ds_r[ch]   <= ds_nxt[ch];
      end
      s1_ts_r <= in_data.timestamp;
    end
  end

  // Stage two: intervals, storage page, decimated page.
  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      ival[ch] = s1_prod_r[ch] + s1_ds_r[ch];
    end
    count_inc = (readout_count_r != {DECIM_W{1'b1}}) ? readout_count_r + 1'b1
                                                     : readout_count_r;
    store_full = ({1'b0, store_index_r} + 1'b1) >= (SSLOT_W+1)'(STORE_RECORDS);
    store_index_nxt = store_full ? '0 : store_index_r + 1'b1;
    store_side_nxt  = store_side_r ^ store_full;

    fwd_take = (ival[0] < valid_limit_r) && (count_inc >= decimation_r);
    fwd_full = fwd_take &&
               (({1'b0, fwd_index_r} + 1'b1) >= (FSLOT_W+1)'(FWD_RECORDS));
    readout_count_nxt = fwd_take ? '0 : count_inc;
    fwd_index_nxt = !fwd_take ? fwd_index_r : (fwd_full ? '0 : fwd_index_r + 1'b1);
    fwd_side_nxt  = fwd_side_r ^ fwd_full;

    out_data_nxt.interval_a      = ival[0];
    out_data_nxt.interval_b      = ival[1];
    out_data_nxt.interval_c      = ival[2];
    out_data_nxt.store_slot      = store_index_r;
    out_data_nxt.store_bank      = store_side_r;
    out_data_nxt.store_page_full = store_full;
    out_data_nxt.page_time       = (store_index_r == '0) ? s1_ts_r : 32'd0;
    out_data_nxt.forward         = fwd_take;
    out_data_nxt.fwd_slot        = fwd_take ? fwd_index_r : '0;
    out_data_nxt.fwd_bank        = fwd_take && fwd_side_r;
    out_data_nxt.fwd_page_full   = fwd_full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      readout_count_r <= '0;
      store_index_r   <= '0;
      store_side_r    <= 1'b0;
      fwd_index_r     <= '0;
      fwd_side_r      <= 1'b0;
    end else begin
      if (s1_adv) begin
        out_valid_r     <= 1'b1;
        readout_count_r <= readout_count_nxt;
        store_index_r   <= store_index_nxt;
        store_side_r    <= store_side_nxt;
        fwd_index_r     <= fwd_index_nxt;
        fwd_side_r      <= fwd_side_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  `TDCID_ASSERT_NOW(a_no_overwrite, out_valid_r && !out_ready, !s1_adv)
  `TDCID_ASSERT_NOW(a_store_idx_range, 1'b1,
    ({1'b0, store_index_r} < (SSLOT_W+1)'(STORE_RECORDS)))
  `TDCID_ASSERT_NOW(a_store_full_slot, out_valid_r && out_data_r.store_page_full,
    ({1'b0, out_data_r.store_slot} == (SSLOT_W+1)'(STORE_RECORDS - 1)))
  `TDCID_ASSERT_NOW(a_fwd_quiet, out_valid_r && !out_data_r.forward,
    (out_data_r.fwd_slot == '0) && !out_data_r.fwd_bank && !out_data_r.fwd_page_full)
  `TDCID_ASSERT_NEXT(a_fwd_clears_count, s1_adv && fwd_take, readout_count_r == '0)

endmodule
`default_nettype wire
